FILE: src/mfm_track_sector_scanner_core_macros.svh
// Assertion helpers for the track sector scanner
`ifndef MFM_TRACK_SECTOR_SCANNER_CORE_MACROS_SVH
`define MFM_TRACK_SECTOR_SCANNER_CORE_MACROS_SVH

// implication check, held off during reset
`define MTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication check, held off during reset
`define MTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/mts_pkg.sv
package mts_pkg;

    localparam int MAX_TRACK_BYTES  = 8192;
    localparam int MAX_SECTORS      = 64;
    localparam int DATA_MARK_WINDOW = 43;

    localparam logic [7:0]  BYTE_A1 = 8'hA1;
    localparam logic [7:0]  BYTE_FE = 8'hFE;
    localparam logic [7:0]  BYTE_F8 = 8'hF8;
    localparam logic [7:0]  BYTE_FB = 8'hFB;
    localparam logic [15:0] CRC_AFTER_SYNC = 16'hCDB4;
    localparam logic [12:0] TRACK_LEN_RESET = 13'd6250;

    localparam logic [1:0] PH_HUNT   = 2'd0;
    localparam logic [1:0] PH_HEADER = 2'd1;
    localparam logic [1:0] PH_WINDOW = 2'd2;
    localparam logic [1:0] PH_DATA   = 2'd3;

    localparam int REG_TRACK_LENGTH = 0;

    // one result as it travels through the queue
    typedef struct packed {
        logic [7:0]  cylinder_id;
        logic [7:0]  head_id;
        logic [7:0]  sector_id;
        logic [7:0]  size_code;
        logic        header_crc_ok;
        logic        has_data;
        logic        data_crc_ok;
        logic [12:0] data_offset;
        logic [10:0] data_length;
        logic [5:0]  sector_number;
        logic        overflow;
        logic        track_done;
    } t_result;

    // bytewise CRC-16-CCITT update
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
        end
        return c;
    endfunction

endpackage

FILE: src/mts_front.sv
// Scanner front: classifies each track byte and emits up to two result requests
module mts_front #(
    parameter int MAX_TRACK_BYTES  = mts_pkg::MAX_TRACK_BYTES,
    parameter int MAX_SECTORS      = mts_pkg::MAX_SECTORS,
    parameter int DATA_MARK_WINDOW = mts_pkg::DATA_MARK_WINDOW
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    input  logic              i_sync,
    input  logic              i_last,
    input  logic [12:0]       i_track_length,
    output logic [1:0]        o_count,
    output mts_pkg::t_result  o_res0,
    output mts_pkg::t_result  o_res1
);
    localparam int SW = $clog2(MAX_SECTORS + 1);

    logic [12:0] r_pos, n_pos;
    logic [1:0]  r_phase, n_phase;
    logic [8:0]  r_prev, n_prev;
    logic [31:0] r_hdr, n_hdr;
    logic [15:0] r_crc, n_crc;
    logic [15:0] r_scrc, n_scrc;
    logic [10:0] r_fcnt, n_fcnt;
    logic [12:0] r_wend, n_wend;
    logic [SW-1:0] r_found, n_found;
    logic [3:0]  r_flags, n_flags;

    logic [13:0] len_t, lim, wend, p14, dlen14;
    logic [10:0] dlen;
    logic        prev_a1;
    logic [12:0] j;
    logic [1:0]  cnt;
    mts_pkg::t_result res0, res1, sect;
    logic        data_ok;
    logic        put_pending;

    always_comb begin
        len_t   = (32'(i_track_length) > MAX_TRACK_BYTES) ? 14'(MAX_TRACK_BYTES)
                                                          : 14'(i_track_length);
        lim     = (len_t >= 14'd8) ? len_t - 14'd8 : 14'd0;
        prev_a1 = (r_prev == {1'b1, mts_pkg::BYTE_A1});
        p14     = 14'(r_pos);
        j       = r_pos - 13'd1;
        dlen    = 11'd128 << r_hdr[25:24];
        dlen14  = 14'(dlen);
        wend    = p14 - 14'd7 + 14'd8 + 14'(DATA_MARK_WINDOW);
    end

    // sector result assembled from the state after this byte's field work
    function automatic mts_pkg::t_result mk(input logic [31:0] h, input logic [3:0] f,
                                            input logic [12:0] we, input logic dok,
                                            input logic [SW-1:0] sf);
        mts_pkg::t_result r;
        r = '0;
        r.cylinder_id   = h[7:0];
        r.head_id       = h[15:8];
        r.sector_id     = h[23:16];
        r.size_code     = h[31:24];
        r.header_crc_ok = f[0];
        r.has_data      = f[1];
        r.data_crc_ok   = f[1] & dok;
        r.data_offset   = f[1] ? we : 13'd0;
        r.data_length   = f[1] ? (11'd128 << h[25:24]) : 11'd0;
        r.sector_number = 6'(sf - SW'(1));
        return r;
    endfunction

    always_comb begin
        n_pos = r_pos; n_phase = r_phase; n_prev = r_prev; n_hdr = r_hdr;
        n_crc = r_crc; n_scrc = r_scrc; n_fcnt = r_fcnt; n_wend = r_wend;
        n_found = r_found; n_flags = r_flags;
        cnt = 2'd0; res0 = '0; res1 = '0; sect = '0;
        data_ok = 1'b0; put_pending = 1'b0;

        // field work for the current phase
        case (r_phase)
            mts_pkg::PH_HEADER: begin
                if (r_fcnt < 11'd4) begin
                    n_hdr = r_hdr | (32'(i_byte) << (5'd8 * r_fcnt[1:0]));
                    n_crc = mts_pkg::crc_byte(r_crc, i_byte);
                end else if (r_fcnt == 11'd4) begin
                    n_scrc = {i_byte, 8'h00};
                end else begin
                    n_scrc = r_scrc | 16'(i_byte);
                end
                n_fcnt = r_fcnt + 11'd1;
                if (n_fcnt >= 11'd6) begin
                    if (n_crc == n_scrc) n_flags[0] = 1'b1;
                    n_wend  = (wend < lim) ? wend[12:0] : lim[12:0];
                    n_fcnt  = 11'd0;
                    n_phase = mts_pkg::PH_WINDOW;
                end
            end
            mts_pkg::PH_WINDOW: begin
                if (r_fcnt >= 11'd1 && prev_a1 && j < r_wend && !i_sync) begin
                    if (i_byte == mts_pkg::BYTE_F8 || i_byte == mts_pkg::BYTE_FB) begin
                        n_crc   = mts_pkg::crc_byte(mts_pkg::CRC_AFTER_SYNC, i_byte);
                        n_wend  = r_pos + 13'd1;
                        n_fcnt  = dlen + 11'd2;
                        n_flags[1] = 1'b1;
                        if ({1'b0, p14} + 15'd3 + 15'(dlen14) > {1'b0, len_t})
                            n_flags[2] = 1'b1;
                        n_phase = mts_pkg::PH_DATA;
                    end else begin
                        put_pending = 1'b1;
                        n_phase = mts_pkg::PH_HUNT;
                    end
                end else if (j >= r_wend) begin
                    put_pending = 1'b1;
                    n_phase = mts_pkg::PH_HUNT;
                end else begin
                    n_fcnt = 11'd1;
                end
            end
            mts_pkg::PH_DATA: begin
                if (r_fcnt > 11'd2) begin
                    n_crc  = mts_pkg::crc_byte(r_crc, i_byte);
                    n_fcnt = r_fcnt - 11'd1;
                end else if (r_fcnt == 11'd2) begin
                    n_scrc = {i_byte, 8'h00};
                    n_fcnt = r_fcnt - 11'd1;
                end else begin
                    n_scrc = r_scrc | 16'(i_byte);
                    n_fcnt = 11'd0;
                    data_ok = (r_crc == n_scrc) && !r_flags[2];
                    put_pending = 1'b1;
                    n_phase = mts_pkg::PH_HUNT;
                end
            end
            default: n_phase = mts_pkg::PH_HUNT;
        endcase

        if (put_pending) begin
            res0 = mk(n_hdr, n_flags, n_wend, data_ok, n_found);
            cnt  = 2'd1;
        end

        // ID mark recognition
        if (!i_last && (n_phase == mts_pkg::PH_HUNT || n_phase == mts_pkg::PH_WINDOW) &&
            prev_a1 && i_byte == mts_pkg::BYTE_FE && ({1'b0, p14} + 15'd7 < {1'b0, len_t}))
        begin
            if (32'(r_found) >= MAX_SECTORS) begin
                n_flags[3] = 1'b1;
            end else begin
                if (n_phase == mts_pkg::PH_WINDOW) begin
                    res0 = mk(n_hdr, n_flags, n_wend, 1'b0, n_found);
                    cnt  = 2'd1;
                end
                n_found = r_found + SW'(1);
                n_hdr   = '0;
                n_crc   = mts_pkg::crc_byte(mts_pkg::CRC_AFTER_SYNC, mts_pkg::BYTE_FE);
                n_scrc  = '0;
                n_fcnt  = '0;
                n_flags = n_flags & 4'b1000;
                n_phase = mts_pkg::PH_HEADER;
            end
        end

        if (i_last) begin
            sect = '0;
            sect.sector_number = (32'(n_found) > 63) ? 6'd63 : 6'(n_found);
            sect.overflow      = n_flags[3];
            sect.track_done    = 1'b1;
            if (n_phase != mts_pkg::PH_HUNT) begin
                res0 = mk(n_hdr, n_flags, n_wend, 1'b0, n_found);
                res1 = sect;
                cnt  = 2'd2;
            end else if (cnt == 2'd1) begin
                res1 = sect;
                cnt  = 2'd2;
            end else begin
                res0 = sect;
                cnt  = 2'd1;
            end
            n_pos = '0; n_phase = mts_pkg::PH_HUNT; n_prev = '0; n_hdr = '0;
            n_crc = mts_pkg::CRC_AFTER_SYNC; n_scrc = '0; n_fcnt = '0; n_wend = '0;
            n_found = '0; n_flags = '0;
        end else begin
            if (r_pos < 13'd8191) n_pos = r_pos + 13'd1;
            n_prev = {i_sync, i_byte};
        end
    end

    assign o_count = i_step ? cnt : 2'd0;
    assign o_res0  = res0;
    assign o_res1  = res1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0; r_phase <= mts_pkg::PH_HUNT; r_prev <= '0; r_hdr <= '0;
            r_crc <= mts_pkg::CRC_AFTER_SYNC; r_scrc <= '0; r_fcnt <= '0; r_wend <= '0;
            r_found <= '0; r_flags <= '0;
        end else if (i_step) begin
            r_pos <= n_pos; r_phase <= n_phase; r_prev <= n_prev; r_hdr <= n_hdr;
            r_crc <= n_crc; r_scrc <= n_scrc; r_fcnt <= n_fcnt; r_wend <= n_wend;
            r_found <= n_found; r_flags <= n_flags;
        end
    end
endmodule

FILE: src/mts_queue.sv
// Result queue: takes up to two requests per cycle, delivers one per cycle while i_ready is high
module mts_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_count,
    input  mts_pkg::t_result  i_res0,
    input  mts_pkg::t_result  i_res1,
    output logic              o_room,
    output logic              o_valid,
    output mts_pkg::t_result  o_res,
    input  logic              i_ready
);
    localparam int DEPTH = 4;

    mts_pkg::t_result r_mem [DEPTH];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt, n_cnt;
    logic       pop;

    assign pop     = o_valid && i_ready;
    assign o_valid = (r_cnt != 3'd0);
    assign o_res   = r_mem[r_rp];
    assign o_room  = (r_cnt <= 3'd2);
    assign n_cnt   = r_cnt + 3'(i_count) - {2'b00, pop};

    always_ff @(posedge i_clk) begin
        if (i_count != 2'd0) r_mem[r_wp] <= i_res0;
        if (i_count == 2'd2) r_mem[r_wp + 2'd1] <= i_res1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + i_count;
            r_rp  <= r_rp + {1'b0, pop};
            r_cnt <= n_cnt;
        end
    end
endmodule

FILE: src/mfm_track_sector_scanner_core.sv
// MFM track sector scanner. One raw track byte is accepted per cycle while the
// queue has room; the scanner front updates the CRC bytewise for each byte. Sector
// and end-of-track results (up to two per byte) go through a four-entry queue to
// the output; input ready drops only while that queue holds three or more
// requests. track_length is APB register 0 at address 0.
module mfm_track_sector_scanner_core #(
    parameter int MAX_TRACK_BYTES  = mts_pkg::MAX_TRACK_BYTES,
    parameter int MAX_SECTORS      = mts_pkg::MAX_SECTORS,
    parameter int DATA_MARK_WINDOW = mts_pkg::DATA_MARK_WINDOW
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_track_byte,
    input  logic        i_sync_mark,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_cylinder_id,
    output logic [7:0]  o_head_id,
    output logic [7:0]  o_sector_id,
    output logic [7:0]  o_size_code,
    output logic        o_header_crc_ok,
    output logic        o_has_data,
    output logic        o_data_crc_ok,
    output logic [12:0] o_data_offset,
    output logic [10:0] o_data_length,
    output logic [5:0]  o_sector_number,
    output logic        o_overflow,
    output logic        o_track_done
);
    `include "mfm_track_sector_scanner_core_macros.svh"

    logic [12:0] r_track_length;
    logic        step;
    logic [1:0]  cnt;
    mts_pkg::t_result res0, res1, qres;

    // configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[1:0] == 2'(mts_pkg::REG_TRACK_LENGTH * 4)) ?
                    {19'd0, r_track_length} : 32'd0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track_length <= mts_pkg::TRACK_LEN_RESET;
        end else if (psel && penable && pwrite &&
                     paddr == 2'(mts_pkg::REG_TRACK_LENGTH * 4)) begin
            r_track_length <= pwdata[12:0];
        end
    end

    assign step = i_valid && o_ready;

    mts_front #(
        .MAX_TRACK_BYTES (MAX_TRACK_BYTES),
        .MAX_SECTORS     (MAX_SECTORS),
        .DATA_MARK_WINDOW(DATA_MARK_WINDOW)
    ) u_front (
        .i_clk, .i_rst_n, .i_step(step), .i_byte(i_track_byte), .i_sync(i_sync_mark),
        .i_last(i_last_byte), .i_track_length(r_track_length),
        .o_count(cnt), .o_res0(res0), .o_res1(res1)
    );

    mts_queue u_queue (
        .i_clk, .i_rst_n, .i_count(cnt), .i_res0(res0), .i_res1(res1),
        .o_room(o_ready), .o_valid(o_valid), .o_res(qres), .i_ready(i_ready)
    );

    assign o_cylinder_id   = qres.cylinder_id;
    assign o_head_id       = qres.head_id;
    assign o_sector_id     = qres.sector_id;
    assign o_size_code     = qres.size_code;
    assign o_header_crc_ok = qres.header_crc_ok;
    assign o_has_data      = qres.has_data;
    assign o_data_crc_ok   = qres.data_crc_ok;
    assign o_data_offset   = qres.data_offset;
    assign o_data_length   = qres.data_length;
    assign o_sector_number = qres.sector_number;
    assign o_overflow      = qres.overflow;
    assign o_track_done    = qres.track_done;

    // the last byte always produces a summary request
    `MTS_ASSERT_IMP(a_last_gives_result, i_clk, i_rst_n, step && i_last_byte, cnt != 2'd0, "last byte without summary")
    // requests only come with an accepted byte
    `MTS_ASSERT_IMP(a_no_idle_request, i_clk, i_rst_n, !step, cnt == 2'd0, "request without byte")
    // an accepted last byte leaves a result to deliver
    `MTS_ASSERT_NEXT(a_result_after_last, i_clk, i_rst_n, step && i_last_byte, o_valid, "summary lost")
endmodule

FILE: tb/tb_mfm_track_sector_scanner_core.sv
module tb_mfm_track_sector_scanner_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 4000;

    // directed row kinds: plain byte, or a byte that runs through / reports the CRC
    typedef enum logic [2:0] {RK_BYTE, RK_START, RK_DATA, RK_CRC_HI, RK_CRC_LO, RK_CRC_BAD}
        t_row_kind;

    typedef struct {
        t_row_kind         kind;
        logic [7:0]        b;
        logic              s;
        logic              l;
        bit                typed;
        mts_pkg::t_result  want;
    } t_dir_row;

    localparam mts_pkg::t_result EMPTY_SUMMARY = '{track_done: 1'b1, default: '0};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid = 1'b0, o_ready;
    logic [7:0]  i_track_byte = '0;
    logic        i_sync_mark = 1'b0, i_last_byte = 1'b0;
    logic        o_valid, i_ready = 1'b0;
    logic [7:0]  o_cylinder_id, o_head_id, o_sector_id, o_size_code;
    logic        o_header_crc_ok, o_has_data, o_data_crc_ok;
    logic [12:0] o_data_offset;
    logic [10:0] o_data_length;
    logic [5:0]  o_sector_number;
    logic        o_overflow, o_track_done;

    mfm_track_sector_scanner_core uut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // scanner state mirrored for prediction
    int unsigned cfg_len = mts_pkg::TRACK_LEN_RESET;
    int unsigned pos, fcount, win_end, n_sectors;
    logic [1:0]  phase;
    logic [8:0]  prev_mark;
    logic [31:0] hdr;
    logic [15:0] crc_acc, crc_st;
    logic [3:0]  flags;

    mts_pkg::t_result expected_results[$];
    int unsigned errors = 0, items_sent = 0, trk_pos = 0;
    bit burst_in = 0, burst_out = 0;

    function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {b, 8'h00};
        repeat (8) r = r[15] ? ((r << 1) ^ 16'h1021) : (r << 1);
        return r;
    endfunction

    function automatic void clear_scan();
        pos = 0; phase = mts_pkg::PH_HUNT; prev_mark = '0; hdr = '0;
        crc_acc = mts_pkg::CRC_AFTER_SYNC;
        crc_st = '0; fcount = 0; win_end = 0; n_sectors = 0; flags = '0;
    endfunction

    function automatic void report_sector(input logic ok);
        mts_pkg::t_result r;
        r = '0;
        r.cylinder_id = hdr[7:0];
        r.head_id = hdr[15:8];
        r.sector_id = hdr[23:16];
        r.size_code = hdr[31:24];
        r.header_crc_ok = flags[0];
        r.has_data = flags[1];
        if (flags[1]) begin
            r.data_crc_ok = ok;
            r.data_offset = win_end[12:0];
            r.data_length = 11'(128 << hdr[25:24]);
        end
        r.sector_number = 6'(n_sectors - 1);
        expected_results.push_back(r);
    endfunction

    // one accepted track byte through the scanner
    function automatic void scan_byte(input logic [7:0] b, input logic s, input logic l);
        int unsigned len_t, lim, wend, dlen;
        bit prev_a1;
        mts_pkg::t_result sm;
        len_t = cfg_len > mts_pkg::MAX_TRACK_BYTES ? mts_pkg::MAX_TRACK_BYTES : cfg_len;
        prev_a1 = (prev_mark == {1'b1, mts_pkg::BYTE_A1});
        case (phase)
            mts_pkg::PH_HEADER: begin
                if (fcount < 4) begin
                    hdr |= 32'(b) << (8 * fcount);
                    crc_acc = crc16_step(crc_acc, b);
                end else if (fcount == 4) begin
                    crc_st = {b, 8'h00};
                end else begin
                    crc_st[7:0] = b;
                end
                fcount++;
                if (fcount >= 6) begin
                    lim = len_t >= 8 ? len_t - 8 : 0;
                    wend = pos - 7 + 8 + mts_pkg::DATA_MARK_WINDOW;
                    if (crc_acc == crc_st) flags[0] = 1'b1;
                    win_end = wend < lim ? wend : lim;
                    fcount = 0;
                    phase = mts_pkg::PH_WINDOW;
                end
            end
            mts_pkg::PH_WINDOW: begin
                if (fcount >= 1 && prev_a1 && (pos - 1) < win_end && !s) begin
                    if (b == mts_pkg::BYTE_F8 || b == mts_pkg::BYTE_FB) begin
                        dlen = 128 << hdr[25:24];
                        crc_acc = crc16_step(mts_pkg::CRC_AFTER_SYNC, b);
                        win_end = (pos + 1) & 13'h1FFF;
                        fcount = dlen + 2;
                        flags[1] = 1'b1;
                        if (pos + 1 + dlen + 2 > len_t) flags[2] = 1'b1;
                        phase = mts_pkg::PH_DATA;
                    end else begin
                        report_sector(1'b0);
                        phase = mts_pkg::PH_HUNT;
                    end
                end else if ((pos - 1) >= win_end) begin
                    report_sector(1'b0);
                    phase = mts_pkg::PH_HUNT;
                end else begin
                    fcount = 1;
                end
            end
            mts_pkg::PH_DATA: begin
                if (fcount > 2) begin
                    crc_acc = crc16_step(crc_acc, b);
                    fcount--;
                end else if (fcount == 2) begin
                    crc_st = {b, 8'h00};
                    fcount--;
                end else begin
                    crc_st[7:0] = b;
                    fcount = 0;
                    report_sector(crc_acc == crc_st && !flags[2]);
                    phase = mts_pkg::PH_HUNT;
                end
            end
            default: phase = mts_pkg::PH_HUNT;
        endcase

        // ID mark detection
        if (!l && (phase == mts_pkg::PH_HUNT || phase == mts_pkg::PH_WINDOW) && prev_a1
                && b == mts_pkg::BYTE_FE && pos + 7 < len_t) begin
            if (n_sectors >= mts_pkg::MAX_SECTORS) begin
                flags[3] = 1'b1;
            end else begin
                if (phase == mts_pkg::PH_WINDOW) report_sector(1'b0);
                n_sectors++;
                hdr = '0;
                crc_acc = crc16_step(mts_pkg::CRC_AFTER_SYNC, mts_pkg::BYTE_FE);
                crc_st = '0;
                fcount = 0;
                flags &= 4'b1000;
                phase = mts_pkg::PH_HEADER;
            end
        end

        if (l) begin
            if (phase != mts_pkg::PH_HUNT) report_sector(1'b0);
            sm = '0;
            sm.sector_number = n_sectors > 63 ? 6'd63 : 6'(n_sectors);
            sm.overflow = flags[3];
            sm.track_done = 1'b1;
            expected_results.push_back(sm);
            clear_scan();
            return;
        end
        if (pos < 8191) pos++;
        prev_mark = {s, b};
    endfunction

    // send one request and predict on acceptance
    task automatic push(input logic [7:0] b, input logic s, input logic l);
        int gap;
        if ($urandom_range(0, 40) == 0) burst_in = !burst_in;
        gap = burst_in ? 0 : $urandom_range(0, 12);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_track_byte = b;
        i_sync_mark = s;
        i_last_byte = l;
        do @(posedge i_clk); while (!o_ready);
        scan_byte(b, s, l);
        items_sent++;
        trk_pos++;
    endtask

    task automatic reg_write(input int idx, input logic [31:0] val);
        @(negedge i_clk);
        i_valid = 1'b0;
        wait (expected_results.size() == 0);
        repeat (20) @(posedge i_clk);
        @(negedge i_clk);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
        paddr = 2'(idx * 4); pwdata = val;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        if (idx == mts_pkg::REG_TRACK_LENGTH) cfg_len = val[12:0];
    endtask

    // one sector: ID field, optionally a data field, with occasional damage
    task automatic send_sector(input bit with_data);
        logic [15:0] c;
        logic [7:0]  n, mk, x;
        logic        sx;
        repeat ($urandom_range(0, 6)) push(8'h4E, 1'b0, 1'b0);
        repeat ($urandom_range(1, 3)) push(mts_pkg::BYTE_A1, 1'b1, 1'b0);
        c = crc16_step(mts_pkg::CRC_AFTER_SYNC, mts_pkg::BYTE_FE);
        push(mts_pkg::BYTE_FE, 1'b0, 1'b0);
        n = $urandom;
        if ($urandom_range(0, 7) != 0) n[1:0] = 2'b00;
        repeat (3) begin
            x = $urandom;
            c = crc16_step(c, x);
            push(x, 1'b0, 1'b0);
        end
        c = crc16_step(c, n);
        push(n, 1'b0, 1'b0);
        if ($urandom_range(0, 9) == 0) c ^= 16'(1 << $urandom_range(0, 15));
        push(c[15:8], 1'b0, 1'b0);
        push(c[7:0], 1'b0, 1'b0);
        if (!with_data) return;
        repeat ($urandom_range(0, 3) == 0 ? $urandom_range(0, 55) : $urandom_range(0, 30))
            push(8'h4E, 1'b0, 1'b0);
        repeat ($urandom_range(1, 3)) push(mts_pkg::BYTE_A1, 1'b1, 1'b0);
        mk = $urandom_range(0, 9) == 0 ? 8'($urandom)
                                       : ($urandom_range(0, 1) ? mts_pkg::BYTE_F8
                                                               : mts_pkg::BYTE_FB);
        c = crc16_step(mts_pkg::CRC_AFTER_SYNC, mk);
        push(mk, $urandom_range(0, 19) == 0, 1'b0);
        repeat (128 << n[1:0]) begin
            x = $urandom;
            sx = $urandom_range(0, 63) == 0;
            c = crc16_step(c, x);
            push(x, sx, 1'b0);
        end
        if ($urandom_range(0, 9) == 0) c ^= 16'(1 << $urandom_range(0, 15));
        push(c[15:8], 1'b0, 1'b0);
        push(c[7:0], 1'b0, 1'b0);
    endtask

    // random track of about nb bytes, closed by a last byte
    task automatic send_track(input int unsigned nb);
        int k;
        trk_pos = 0;
        while (trk_pos < nb) begin
            k = $urandom_range(0, 99);
            if (k < 55) begin
                send_sector($urandom_range(0, 4) != 0);
            end else begin
                repeat ($urandom_range(1, 20)) begin
                    case ($urandom_range(0, 3))
                        0: push(mts_pkg::BYTE_A1, $urandom_range(0, 1), 1'b0);
                        1: push(mts_pkg::BYTE_FE, $urandom_range(0, 7) == 0, 1'b0);
                        default: push(8'($urandom), $urandom_range(0, 7) == 0, 1'b0);
                    endcase
                end
            end
        end
        push(8'($urandom), $urandom_range(0, 1), 1'b1);
    endtask

    task automatic send_random_tracks(input int count);
        int unsigned cap;
        repeat (count) begin
            cap = cfg_len < 200 ? cfg_len : 200;
            send_track($urandom_range(8, cap) + ($urandom_range(0, 3) == 0 ? 40 : 0));
        end
    endtask

    // directed table: extremes, early last byte, ID mark in window, bad CRC
    t_dir_row dir_rows [26] = '{
        '{RK_BYTE,   8'h00, 1'b0, 1'b1, 1'b1, EMPTY_SUMMARY},
        '{RK_BYTE,   8'hA1, 1'b1, 1'b0, 1'b0, '0},
        '{RK_BYTE,   8'hA1, 1'b1, 1'b0, 1'b0, '0},
        '{RK_BYTE,   8'hA1, 1'b1, 1'b0, 1'b0, '0},
        '{RK_START,  8'hFE, 1'b0, 1'b0, 1'b0, '0},
        '{RK_DATA,   8'hFF, 1'b0, 1'b0, 1'b0, '0},
        '{RK_DATA,   8'hFF, 1'b0, 1'b0, 1'b0, '0},
        '{RK_DATA,   8'h00, 1'b0, 1'b0, 1'b0, '0},
        '{RK_DATA,   8'hFC, 1'b0, 1'b0, 1'b0, '0},
        '{RK_CRC_HI, 8'h00, 1'b0, 1'b0, 1'b0, '0},
        '{RK_CRC_LO, 8'h00, 1'b0, 1'b0, 1'b0, '0},
        '{RK_BYTE,   8'h4E, 1'b0, 1'b0, 1'b0, '0},
        '{RK_BYTE,   8'hA1, 1'b1, 1'b0, 1'b0, '0},
        '{RK_START,  8'hFE, 1'b0, 1'b0, 1'b0, '0},
        '{RK_DATA,   8'h00, 1'b0, 1'b0, 1'b0, '0},
        '{RK_DATA,   8'h00, 1'b0, 1'b0, 1'b0, '0},
        '{RK_DATA,   8'hFF, 1'b0, 1'b0, 1'b0, '0},
        '{RK_DATA,   8'h03, 1'b0, 1'b0, 1'b0, '0},
        '{RK_CRC_HI, 8'h00, 1'b0, 1'b0, 1'b0, '0},
        '{RK_CRC_BAD, 8'h00, 1'b0, 1'b0, 1'b0, '0},
        '{RK_BYTE,   8'hA1, 1'b1, 1'b0, 1'b0, '0},
        '{RK_BYTE,   8'h55, 1'b0, 1'b0, 1'b0, '0},
        '{RK_BYTE,   8'hA1, 1'b1, 1'b0, 1'b0, '0},
        '{RK_START,  8'hFE, 1'b0, 1'b0, 1'b0, '0},
        '{RK_DATA,   8'h01, 1'b0, 1'b0, 1'b0, '0},
        '{RK_BYTE,   8'h02, 1'b0, 1'b1, 1'b0, '0}
    };

    // stimulus
    initial begin
        logic [15:0] tx_crc;
        logic [7:0]  b;
        clear_scan();
        tx_crc = mts_pkg::CRC_AFTER_SYNC;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[i]) begin
            case (dir_rows[i].kind)
                RK_START: begin
                    b = dir_rows[i].b;
                    tx_crc = crc16_step(mts_pkg::CRC_AFTER_SYNC, b);
                end
                RK_DATA: begin
                    b = dir_rows[i].b;
                    tx_crc = crc16_step(tx_crc, b);
                end
                RK_CRC_HI: b = tx_crc[15:8];
                RK_CRC_LO: b = tx_crc[7:0];
                RK_CRC_BAD: b = tx_crc[7:0] ^ 8'h01;
                default: b = dir_rows[i].b;
            endcase
            push(b, dir_rows[i].s, dir_rows[i].l);
            if (dir_rows[i].typed) begin
                void'(expected_results.pop_back());
                expected_results.push_back(dir_rows[i].want);
            end
        end
        send_random_tracks(2);

        // shortest track
        reg_write(mts_pkg::REG_TRACK_LENGTH, 32'd16);
        send_random_tracks(3);

        // longest track: sector table overflow
        reg_write(mts_pkg::REG_TRACK_LENGTH, 32'd8191);
        trk_pos = 0;
        repeat (66) send_sector(1'b0);
        push(8'h00, 1'b0, 1'b1);

        while (items_sent < 1950) begin
            reg_write(mts_pkg::REG_TRACK_LENGTH, $urandom_range(17, 1500));
            send_random_tracks(1);
        end

        @(negedge i_clk);
        i_valid = 1'b0;
        wait (expected_results.size() == 0);
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // result side back-pressure
    initial begin
        int n;
        wait (i_rst_n);
        forever begin
            if ($urandom_range(0, 40) == 0) burst_out = !burst_out;
            n = burst_out ? 0 : $urandom_range(0, 12);
            @(negedge i_clk);
            i_ready = (n == 0);
            if (n > 0) begin
                repeat (n) @(negedge i_clk);
                i_ready = 1'b1;
            end
            do @(posedge i_clk); while (!o_valid);
        end
    end

    task automatic check_field(input string name, input int unsigned e, input int unsigned a);
        if (e != a) begin
            $error("%s: expected %0d, got %0d", name, e, a);
            errors++;
        end
    endtask

    // compare each delivered result with the oldest prediction
    always @(posedge i_clk) begin
        mts_pkg::t_result e;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                $error("result with no request pending");
                errors++;
            end else begin
                e = expected_results.pop_front();
                check_field("cylinder_id", e.cylinder_id, o_cylinder_id);
                check_field("head_id", e.head_id, o_head_id);
                check_field("sector_id", e.sector_id, o_sector_id);
                check_field("size_code", e.size_code, o_size_code);
                check_field("header_crc_ok", e.header_crc_ok, o_header_crc_ok);
                check_field("has_data", e.has_data, o_has_data);
                check_field("data_crc_ok", e.data_crc_ok, o_data_crc_ok);
                check_field("data_offset", e.data_offset, o_data_offset);
                check_field("data_length", e.data_length, o_data_length);
                check_field("sector_number", e.sector_number, o_sector_number);
                check_field("overflow", e.overflow, o_overflow);
                check_field("track_done", e.track_done, o_track_done);
            end
        end
    end

    // watchdog on cycles without any transfer
    int unsigned quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (psel && penable) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

FILE: mfm_track_sector_scanner_core.f
+incdir+src
src/mts_pkg.sv
src/mts_front.sv
src/mts_queue.sv
src/mfm_track_sector_scanner_core.sv
tb/tb_mfm_track_sector_scanner_core.sv
